FILE: design/s3f_pkg.sv
// s3f_pkg: shared types and constants of the 3x3 sharpening stream filter.
// Used by every module of the block but s3f_ram; depends on nothing.
`timescale 1ns / 1ps

package s3f_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 16;
  localparam int CHAN_W     = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST   = 12'd640;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST  = 16'd480;
  localparam logic [CHAN_W-1:0]  CHANNEL_COUNT_RST = 3'd3;

  localparam int MIN_DIM = 3;

  // one classified sample with its neighborhood, as queued for the back end
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] center;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] up;
    logic                has_prev;
    logic                calc;
    logic                last_row;
    logic                end_of_row;
  } s3f_item_t;

  typedef enum logic {
    BK_FIRST,
    BK_SECOND
  } s3f_back_state_t;

endpackage

FILE: design/s3f_ram.sv
// s3f_ram: generic single-write, single-read RAM with registered read data.
// Read-before-write on a shared address. No dependencies.
`timescale 1ns / 1ps

module s3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/s3f_front.sv
// s3f_front: sample intake, raster position tracking, line stores and
// neighborhood gathering. Uses s3f_pkg and s3f_ram.
`timescale 1ns / 1ps

module s3f_front import s3f_pkg::*; #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4,
  parameter int Q_DEPTH      = 4,
  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS,
  localparam int SW    = $clog2(DEPTH + 1),
  localparam int CW    = $clog2(MAX_CHANNELS + 1),
  localparam int LW    = $clog2(Q_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [SW-1:0]       stride,
  input  logic [CW-1:0]       ch,
  input  logic [IMG_H_W-1:0]  img_height,
  input  logic [LW-1:0]       q_level,
  output logic                push,
  output s3f_item_t           push_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [AW-1:0]      col_r, col_nxt;
  logic [IMG_H_W-1:0] row_r, row_nxt;

  logic               accept;
  logic [AW-1:0]      c;
  logic [SW:0]        c_ahead;
  logic [AW-1:0]      ahead_addr;
  logic               right_ok, last_row, end_of_row, has_prev, calc;

  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [AW-1:0]       s1_addr_r;
  logic                s1_has_prev_r, s1_calc_r, s1_last_row_r, s1_eor_r, s1_right_ok_r;

  logic [SAMPLE_W-1:0] center, right_raw, up;
  logic [SAMPLE_W-1:0] hist_r [MAX_CHANNELS];
  logic [HW-1:0]       ch_idx;

  // s1 is always drained into the queue, so credit covers it
  assign in_stall = !rst_n ||
                    (({1'b0, q_level} + (LW+1)'(s1_valid_r)) >= (LW+1)'(Q_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    c          = (SW'(col_r) >= stride) ? AW'(stride - SW'(1)) : col_r;
    c_ahead    = (SW+1)'(c) + (SW+1)'(ch);
    right_ok   = c_ahead < (SW+1)'(stride);
    ahead_addr = right_ok ? AW'(c_ahead) : c;
    last_row   = row_r >= (img_height - IMG_H_W'(1));
    end_of_row = SW'(c) == (stride - SW'(1));
    has_prev   = row_r != '0;
    calc       = (row_r > IMG_H_W'(1)) && (SW'(c) >= SW'(ch)) && right_ok;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (end_of_row) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + IMG_H_W'(1);
      end else begin
        col_nxt = c + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r   <= in_sample;
      s1_addr_r     <= c;
      s1_has_prev_r <= has_prev;
      s1_calc_r     <= calc;
      s1_last_row_r <= last_row;
      s1_eor_r      <= end_of_row;
      s1_right_ok_r <= right_ok;
    end
  end

  // recent line is kept twice to serve the center and right-hand reads
  s3f_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_recent_here (
    .clk   (clk),
    .we    (accept),
    .waddr (c),
    .wdata (in_sample),
    .re    (accept),
    .raddr (c),
    .rdata (center)
  );

  s3f_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_recent_ahead (
    .clk   (clk),
    .we    (accept),
    .waddr (c),
    .wdata (in_sample),
    .re    (accept),
    .raddr (ahead_addr),
    .rdata (right_raw)
  );

  s3f_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_older (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (center),
    .re    (accept),
    .raddr (c),
    .rdata (up)
  );

  assign ch_idx = HW'(ch - CW'(1));

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int i = MAX_CHANNELS - 1; i > 0; i--) begin
        hist_r[i] <= hist_r[i-1];
      end
      hist_r[0] <= center;
    end
  end

  assign push = s1_valid_r;

  always_comb begin
    push_item.sample     = s1_sample_r;
    push_item.center     = center;
    push_item.left       = hist_r[ch_idx];
    push_item.right      = s1_right_ok_r ? right_raw : '0;
    push_item.up         = up;
    push_item.has_prev   = s1_has_prev_r;
    push_item.calc       = s1_calc_r;
    push_item.last_row   = s1_last_row_r;
    push_item.end_of_row = s1_eor_r;
  end

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_row |=> col_r == '0)
    else $error("column did not return to zero after end of row");

endmodule

FILE: design/s3f_fifo.sv
// s3f_fifo: short queue of classified items between front and back end.
// Uses s3f_pkg.
`timescale 1ns / 1ps

module s3f_fifo import s3f_pkg::*; #(
  parameter int DEPTH = 4,
  localparam int LW   = $clog2(DEPTH + 1)
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  s3f_item_t wr_item,
  input  logic      rd_en,
  output s3f_item_t rd_item,
  output logic      empty,
  output logic [LW-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  s3f_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [LW-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + LW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item = mem_r[rd_ptr_r];
  assign empty   = count_r == '0;
  assign level   = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !rd_en |-> count_r != LW'(DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> count_r != '0)
    else $error("queue underflow");

endmodule

FILE: design/s3f_back.sv
// s3f_back: computes the sharpened value and expands each item into its
// results through the output register. Uses s3f_pkg.
`timescale 1ns / 1ps

module s3f_back import s3f_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  s3f_item_t           head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_pixel_value,
  output logic                out_run_last,
  output logic                out_frame_last
);

  s3f_back_state_t state_r, state_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] pixel_r;
  logic                run_last_r, frame_last_r, pend_frame_r;

  logic                slot_free, load, ld_run, ld_frame, pend_capture;
  logic [SAMPLE_W-1:0] ld_value;
  logic [ACC_W-1:0]    sum_pos, sum_neg;
  logic signed [ACC_W-1:0] acc;
  logic [SAMPLE_W-1:0] sharp;

  always_comb begin
    sum_pos = {2'b00, head.center, 2'b00} + {4'b0000, head.center};
    sum_neg = {4'b0000, head.left} + {4'b0000, head.right} +
              {4'b0000, head.up} + {4'b0000, head.sample};
    acc     = $signed(sum_pos) - $signed(sum_neg);
    if (acc[ACC_W-1]) begin
      sharp = '0;
    end else if (|acc[ACC_W-2:SAMPLE_W]) begin
      sharp = '1;
    end else begin
      sharp = acc[SAMPLE_W-1:0];
    end
  end

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_FIRST: begin
        if (slot_free && !q_empty && head.has_prev && head.last_row) begin
          state_nxt = BK_SECOND;
        end
      end
      BK_SECOND: begin
        if (slot_free) begin
          state_nxt = BK_FIRST;
        end
      end
      default: state_nxt = BK_FIRST;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    load         = 1'b0;
    ld_value     = '0;
    ld_run       = 1'b1;
    ld_frame     = 1'b0;
    pend_capture = 1'b0;
    case (state_r)
      BK_FIRST: begin
        if (slot_free && !q_empty) begin
          pop = 1'b1;
          if (head.has_prev) begin
            load         = 1'b1;
            ld_value     = head.calc ? sharp : '0;
            ld_run       = !head.last_row;
            pend_capture = head.last_row;
          end else if (head.last_row) begin
            load     = 1'b1;
            ld_frame = head.end_of_row;
          end
        end
      end
      BK_SECOND: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_frame = pend_frame_r;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (slot_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r      <= ld_value;
      run_last_r   <= ld_run;
      frame_last_r <= ld_frame;
    end
    if (pend_capture) begin
      pend_frame_r <= head.end_of_row;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = pixel_r;
  assign out_run_last    = run_last_r;
  assign out_frame_last  = frame_last_r;

  a_second_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_SECOND |-> out_valid_r)
    else $error("trailing zero pending without a first result");

  a_frame_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && frame_last_r |-> run_last_r)
    else $error("frame end flagged on a result that is not last of its sample");

endmodule

FILE: design/sharpen_3x3_stream_filter.sv
// Laplacian 3x3 sharpening filter on a raster stream of interleaved 8-bit
// channel samples: 5*center minus its four neighbors, clamped to 0..255, with
// the outer pixel frame forced to zero. Results for row r-1 come out while
// row r streams in; each last-row sample adds a trailing zero. One sample is
// taken per clock while in_stall is low; a last-row sample loads the single
// output register with both its result and its trailing zero, so intake
// slows on the last row. Samples pass the s1 register, the queue and then
// the output register. Line stores are RAMs of MAX_WIDTH*MAX_CHANNELS bytes
// (the recent line held twice for its two read addresses) and need no
// clearing after reset. Uses s3f_pkg, s3f_ram, s3f_front, s3f_fifo, s3f_back.
`timescale 1ns / 1ps

module sharpen_3x3_stream_filter import s3f_pkg::*; #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SAMPLE_W-1:0]   out_pixel_value,
  output logic                  out_run_last,
  output logic                  out_frame_last
);

  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int SW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = $clog2(MAX_CHANNELS + 1);
  localparam int LW    = $clog2(QUEUE_DEPTH + 1);

  logic [IMG_W_W-1:0] image_width_r;
  logic [IMG_H_W-1:0] image_height_r;
  logic [CHAN_W-1:0]  channel_count_r;

  logic [WW-1:0]      w_eff;
  logic [CW-1:0]      ch_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic [SW-1:0]      stride;

  logic               push, pop, q_empty;
  s3f_item_t          push_item, head;
  logic [LW-1:0]      q_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= IMAGE_WIDTH_RST;
      image_height_r  <= IMAGE_HEIGHT_RST;
      channel_count_r <= CHANNEL_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width_r   <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_r  <= cfg_data[IMG_H_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_width_r) < MIN_DIM) begin
      w_eff = WW'(MIN_DIM);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width_r);
    end

    if (channel_count_r == '0) begin
      ch_eff = CW'(1);
    end else if (32'(channel_count_r) > MAX_CHANNELS) begin
      ch_eff = CW'(MAX_CHANNELS);
    end else begin
      ch_eff = CW'(channel_count_r);
    end

    h_eff  = (32'(image_height_r) < MIN_DIM) ? IMG_H_W'(MIN_DIM) : image_height_r;
    stride = SW'(w_eff) * SW'(ch_eff);
  end

  s3f_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .Q_DEPTH      (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .stride     (stride),
    .ch         (ch_eff),
    .img_height (h_eff),
    .q_level    (q_level),
    .push       (push),
    .push_item  (push_item)
  );

  s3f_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_item (push_item),
    .rd_en   (pop),
    .rd_item (head),
    .empty   (q_empty),
    .level   (q_level)
  );

  s3f_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_value (out_pixel_value),
    .out_run_last    (out_run_last),
    .out_frame_last  (out_frame_last)
  );

endmodule
